@@ src/stdiff_pkg.sv @@
// Shared widths, codes, reset values and saturation helper of the super-twisting differentiator.
`timescale 1ns / 1ps
package stdiff_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned MAG_W      = DATA_W + 1;
  localparam int unsigned SAT_W      = DATA_W + 4;
  localparam int unsigned SMAG_W     = FRAC_W + 1;
  localparam int unsigned ROOT_W     = (MAG_W + FRAC_W + 1) / 2;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned ROOT_CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned MUL_A_W    = DATA_W + ROOT_W - FRAC_W;
  localparam int unsigned MUL_B_W    = DATA_W;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_B_W + 1);
  localparam int unsigned CLAMP_W    = DATA_W + 3;
  localparam int unsigned DEN_W      = MAG_W + 1;
  localparam int unsigned DREM_W     = MAG_W + 2;
  localparam int unsigned DIV_CNT_W  = $clog2(FRAC_W + 1);
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [SMAG_W-1:0]  ONE_Q     = SMAG_W'(1) << FRAC_W;
  localparam logic [MUL_A_W-1:0] MAG_LIMIT = MUL_A_W'(1) << (DATA_W + 2);

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  localparam logic [DATA_W-1:0] LAMBDA_RST = DATA_W'(98304);
  localparam logic [DATA_W-1:0] ALPHA_RST  = DATA_W'(72090);
  localparam logic [DATA_W-1:0] SMOOTH_RST = DATA_W'(656);
  localparam logic [DATA_W-1:0] STEP_RST   = DATA_W'(4294967);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWITCH_MODE = 3'd0,
    CFG_LAMBDA_GAIN = 3'd1,
    CFG_ALPHA_GAIN  = 3'd2,
    CFG_SMOOTH      = 3'd3,
    CFG_STEP_TIME   = 3'd4
  } stdiff_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_ROOT,
    ST_DIV,
    ST_MUL_LR,
    ST_MUL_PS,
    ST_DERIV,
    ST_MUL_SD,
    ST_MUL_AS,
    ST_MUL_SI,
    ST_OUT
  } stdiff_state_e;

  // Completion status of a serial unit.
  typedef struct packed {
    logic busy;
    logic done;
  } stdiff_unit_stat_t;

  function automatic logic [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[DATA_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[DATA_W-1:0];
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

@@ src/stdiff_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module stdiff_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [stdiff_pkg::MUL_A_W-1:0]     a_i,
  input  logic [stdiff_pkg::MUL_B_W-1:0]     b_i,
  output logic [stdiff_pkg::PROD_W-1:0]      prod_o,
  output stdiff_pkg::stdiff_unit_stat_t      stat_o
);
  import stdiff_pkg::*;

  logic [PROD_W-1:0]    p_q, p_d;
  logic [MUL_A_W-1:0]   a_q, a_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MUL_A_W:0]     upper;

  always_comb begin
    upper  = {1'b0, p_q[PROD_W-1:MUL_B_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d   = {{MUL_A_W{1'b0}}, b_i};
      a_d   = a_i;
      cnt_d = MUL_CNT_W'(MUL_B_W);
    end else if (cnt_q != '0) begin
      // add on the low bit, then shift the whole product right
      p_d    = {upper, p_q[MUL_B_W-1:1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == MUL_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign prod_o      = p_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

@@ src/stdiff_root.sv @@
// Restoring square root, one root bit per cycle, of a magnitude scaled by the fraction bits.
`timescale 1ns / 1ps
module stdiff_root (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [stdiff_pkg::MAG_W-1:0]     mag_i,
  output logic [stdiff_pkg::ROOT_W-1:0]    root_o,
  output stdiff_pkg::stdiff_unit_stat_t    stat_o
);
  import stdiff_pkg::*;

  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [REM_W+1:0]      remw, trial, diff;
  logic                  ge;

  always_comb begin
    remw   = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = {{(REM_W - ROOT_W){1'b0}}, root_q, 2'b01};
    diff   = remw - trial;
    ge     = (remw >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = RAD_W'({mag_i, {FRAC_W{1'b0}}});
      rem_d  = '0;
      root_d = '0;
      cnt_d  = ROOT_CNT_W'(ROOT_W);
    end else if (cnt_q != '0) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = ge ? diff[REM_W-1:0] : remw[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == ROOT_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

@@ src/super_twisting_differentiator.sv @@
// Top level of the super-twisting differentiator: sequencer, divider, state and ports.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | sink      | in_valid_i / in_stall_o   | sample_i
//  out      | source    | out_valid_o / out_stall_i | derivative_o, tracking_error_o
//  cfg      | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Per sample the work is five 32-step products on the shared bit-serial multiplier, a
// 25-step square root and, in sigmoid mode with a nonzero error and width, a 16-step divide.
// One sample is in work at a time.
// Reset clears the estimate and the integral and returns the mode and settings to their defaults; no clearing pass.
// A result waits in the output register under stall while the next sample is taken in;
// only the final write of the following result waits for that register to drain.
`timescale 1ns / 1ps
module super_twisting_differentiator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [stdiff_pkg::DATA_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [stdiff_pkg::DATA_W-1:0] derivative_o,
  output logic signed [stdiff_pkg::DATA_W-1:0] tracking_error_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [stdiff_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stdiff_pkg::DATA_W-1:0]       cfg_data_i
);
  import stdiff_pkg::*;

  stdiff_state_e state_q, state_d;

  // configuration registers
  logic              mode_q;
  logic [DATA_W-1:0] lambda_q, alpha_q, smooth_q, step_q;

  // filter state
  logic [DATA_W-1:0] est_q, int_q;

  // per-sample work registers
  logic [DATA_W-1:0]    sample_q, deriv_q, am_q;
  logic                 e_neg_q, need_div_q, go_q;
  logic [MAG_W-1:0]     emag_q;
  logic [SMAG_W-1:0]    smag_q;
  logic [MUL_A_W-1:0]   p1_q;
  logic [CLAMP_W-1:0]   cm_q;
  logic [DREM_W-1:0]    drem_q;
  logic [DEN_W-1:0]     den_q;
  logic [FRAC_W-1:0]    dquo_q;
  logic [DIV_CNT_W-1:0] dcnt_q;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_deriv_q, out_terr_q;

  // serial units
  logic                 mul_start, root_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [ROOT_W-1:0]    root;
  stdiff_unit_stat_t    mul_stat, root_stat;

  logic in_take, out_free, mul_state, unit_done;
  logic signed [MAG_W-1:0] e;
  logic [MAG_W-1:0]        emag;
  logic [DREM_W-1:0]       drem2;
  logic                    dge;
  logic [MUL_A_W-1:0]      cprod;
  logic [DATA_W-1:0]       dabs;
  logic signed [SAT_W-1:0] cterm, dterm, iterm;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign mul_state = (state_q == ST_MUL_LR) || (state_q == ST_MUL_PS) ||
                     (state_q == ST_MUL_SD) || (state_q == ST_MUL_AS) ||
                     (state_q == ST_MUL_SI);
  assign unit_done = mul_state ? mul_stat.done : root_stat.done;

  // error and its magnitude, one extra bit keeps it exact
  assign e    = $signed({est_q[DATA_W-1], est_q}) - $signed({sample_q[DATA_W-1], sample_q});
  assign emag = e[MAG_W-1] ? MAG_W'(-e) : MAG_W'(e);

  // one quotient bit of the sigmoid divide
  assign drem2 = {drem_q[DREM_W-2:0], 1'b0};
  assign dge   = (drem2 >= {1'b0, den_q});

  assign cprod = prod[FRAC_W +: MUL_A_W];
  assign dabs  = deriv_q[DATA_W-1] ? DATA_W'(-deriv_q) : deriv_q;

  // apply signs to the correction, estimate step and integral step
  always_comb begin
    if (e_neg_q) cterm = -$signed(SAT_W'(cm_q));
    else cterm = $signed(SAT_W'(cm_q));
    if (deriv_q[DATA_W-1]) dterm = -$signed(SAT_W'(prod[DATA_W +: DATA_W]));
    else dterm = $signed(SAT_W'(prod[DATA_W +: DATA_W]));
    if (e_neg_q) iterm = $signed(SAT_W'(prod[DATA_W +: DATA_W]));
    else iterm = -$signed(SAT_W'(prod[DATA_W +: DATA_W]));
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_LR: begin
        mul_a = MUL_A_W'(lambda_q);
        mul_b = MUL_B_W'(root);
      end
      ST_MUL_PS: begin
        mul_a = p1_q;
        mul_b = MUL_B_W'(smag_q);
      end
      ST_MUL_SD: begin
        mul_a = MUL_A_W'(step_q);
        mul_b = dabs;
      end
      ST_MUL_AS: begin
        mul_a = MUL_A_W'(alpha_q);
        mul_b = MUL_B_W'(smag_q);
      end
      ST_MUL_SI: begin
        mul_a = MUL_A_W'(step_q);
        mul_b = am_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_ERR;
      ST_ERR:    state_d = ST_ROOT;
      ST_ROOT:   if (go_q && unit_done) state_d = need_div_q ? ST_DIV : ST_MUL_LR;
      ST_DIV:    if (dcnt_q == DIV_CNT_W'(1)) state_d = ST_MUL_LR;
      ST_MUL_LR: if (go_q && unit_done) state_d = ST_MUL_PS;
      ST_MUL_PS: if (go_q && unit_done) state_d = ST_DERIV;
      ST_DERIV:  state_d = ST_MUL_SD;
      ST_MUL_SD: if (go_q && unit_done) state_d = ST_MUL_AS;
      ST_MUL_AS: if (go_q && unit_done) state_d = ST_MUL_SI;
      ST_MUL_SI: if (go_q && unit_done) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs: stall the input while busy, launch each unit once per state
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_start  = mul_state && !go_q;
    root_start = (state_q == ST_ROOT) && !go_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (mul_state || (state_q == ST_ROOT)) && !(go_q && unit_done);
    end
  end

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      lambda_q <= LAMBDA_RST;
      alpha_q  <= ALPHA_RST;
      smooth_q <= SMOOTH_RST;
      step_q   <= STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SWITCH_MODE: mode_q   <= cfg_data_i[0];
        CFG_LAMBDA_GAIN: lambda_q <= cfg_data_i;
        CFG_ALPHA_GAIN:  alpha_q  <= cfg_data_i;
        CFG_SMOOTH:      smooth_q <= cfg_data_i;
        CFG_STEP_TIME:   step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // estimate and integral: written back at the end of their products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      int_q <= '0;
    end else begin
      if (state_q == ST_MUL_SD && go_q && unit_done)
        est_q <= sat_data($signed({{(SAT_W - DATA_W){est_q[DATA_W-1]}}, est_q}) + dterm);
      if (state_q == ST_MUL_SI && go_q && unit_done)
        int_q <= sat_data($signed({{(SAT_W - DATA_W){int_q[DATA_W-1]}}, int_q}) + iterm);
    end
  end

  // per-sample datapath
  always_ff @(posedge clk_i) begin
    if (in_take) sample_q <= sample_i;
    case (state_q)
      ST_ERR: begin
        e_neg_q    <= e[MAG_W-1];
        emag_q     <= emag;
        smag_q     <= (emag == '0) ? '0 : ONE_Q;
        need_div_q <= (emag != '0) && mode_q && (smooth_q != '0);
        drem_q     <= DREM_W'(emag);
        den_q      <= DEN_W'(emag) + DEN_W'(smooth_q);
        dcnt_q     <= DIV_CNT_W'(FRAC_W);
      end
      ST_DIV: begin
        drem_q <= dge ? (drem2 - {1'b0, den_q}) : drem2;
        dquo_q <= {dquo_q[FRAC_W-2:0], dge};
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == DIV_CNT_W'(1)) smag_q <= SMAG_W'({dquo_q[FRAC_W-2:0], dge});
      end
      ST_MUL_LR: if (go_q && unit_done) p1_q <= cprod;
      ST_MUL_PS: begin
        if (go_q && unit_done)
          cm_q <= (cprod > MAG_LIMIT) ? CLAMP_W'(MAG_LIMIT) : cprod[CLAMP_W-1:0];
      end
      ST_DERIV: begin
        deriv_q <= sat_data($signed({{(SAT_W - DATA_W){int_q[DATA_W-1]}}, int_q}) - cterm);
      end
      ST_MUL_AS: if (go_q && unit_done) am_q <= prod[FRAC_W +: DATA_W];
      default: ;
    endcase
  end

  // output register: hold under stall, drop the beat once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_deriv_q <= deriv_q;
      out_terr_q  <= sat_data($signed({{(SAT_W - DATA_W){est_q[DATA_W-1]}}, est_q}) -
                              $signed({{(SAT_W - DATA_W){sample_q[DATA_W-1]}}, sample_q}));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign derivative_o     = out_deriv_q;
  assign tracking_error_o = out_terr_q;

  stdiff_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  stdiff_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .mag_i   (emag_q),
    .root_o  (root),
    .stat_o  (root_stat)
  );

endmodule

@@ src/stdiff_checker.sv @@
// Port-level checker of the super-twisting differentiator and its bind.
`timescale 1ns / 1ps
module stdiff_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [stdiff_pkg::DATA_W-1:0] derivative_o,
  input logic signed [stdiff_pkg::DATA_W-1:0] tracking_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(derivative_o) && $stable(tracking_error_o))
    else $error("result payload changed under stall");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared right after a sample beat");

endmodule

bind super_twisting_differentiator stdiff_checker u_stdiff_checker (.*);

@@ sim/stdiff_derivative_checker.sv @@
// Channel monitor, derivative predictor and result comparison for the super-twisting differentiator.
`timescale 1ns / 1ps
module stdiff_derivative_checker
  import stdiff_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] derivative_i,
  input  logic signed [DATA_W-1:0] tracking_error_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       results_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] derivative;
    logic signed [DATA_W-1:0] tracking_error;
  } diff_result_t;

  localparam longint SAT_MAX = (64'sd1 <<< (DATA_W - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam logic [63:0] CLAMP_LIMIT = 64'd1 << (DATA_W + 2);
  localparam logic [63:0] UNIT_Q = 64'd1 << FRAC_W;

  diff_result_t expected_results[$];

  logic        mode_q;
  logic [63:0] lambda_q, alpha_q, width_q, dt_q;
  longint      estimate_q, integral_q;

  function automatic longint saturate(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // (a * b) >> sh, pinned to all ones when it no longer fits 64 bits
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] clamp_magnitude(logic [63:0] m);
    return (m > CLAMP_LIMIT) ? CLAMP_LIMIT : m;
  endfunction

  // floor(sqrt(m * 2^FRAC_W)), digit by digit
  function automatic logic [63:0] error_root(logic [63:0] m);
    logic [127:0] x, root, rem, trial;
    x = {64'd0, m} << FRAC_W;
    root = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | x[2*k +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic [63:0] sigmoid_magnitude(logic [63:0] m, logic [63:0] w);
    logic [63:0] den, rem, q;
    if (w == 0) return UNIT_Q;
    den = m + w;
    rem = m;
    q = 0;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Advance the estimate and integral by one sample; return the result it yields.
  function automatic diff_result_t predict_derivative(logic signed [DATA_W-1:0] s);
    longint      smp, err, deriv, dm, im, terr;
    logic [63:0] emag, smag, cmag;
    int          esgn;
    diff_result_t r;
    smp = s;
    err = estimate_q - smp;
    esgn = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
    emag = (err < 0) ? -err : err;
    if (esgn == 0) smag = 0;
    else if (!mode_q) smag = UNIT_Q;
    else smag = sigmoid_magnitude(emag, width_q);
    cmag = clamp_magnitude(scaled_product(scaled_product(lambda_q, error_root(emag), FRAC_W),
                                          smag, FRAC_W));
    deriv = saturate(integral_q - esgn * longint'(cmag));
    dm = longint'(clamp_magnitude(scaled_product(dt_q, (deriv < 0) ? -deriv : deriv, 32)));
    estimate_q = saturate(estimate_q + ((deriv < 0) ? -dm : ((deriv > 0) ? dm : 0)));
    im = longint'(clamp_magnitude(scaled_product(dt_q, scaled_product(alpha_q, smag, FRAC_W),
                                                 32)));
    integral_q = saturate(integral_q - esgn * im);
    terr = saturate(estimate_q - smp);
    r.derivative = deriv[DATA_W-1:0];
    r.tracking_error = terr[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    diff_result_t want;
    if (!rst_ni) begin
      mode_q <= 1'b0;
      lambda_q <= 64'(LAMBDA_RST);
      alpha_q <= 64'(ALPHA_RST);
      width_q <= 64'(SMOOTH_RST);
      dt_q <= 64'(STEP_RST);
      estimate_q = 0;
      integral_q = 0;
      expected_results.delete();
      errors_o = 0;
      pending_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SWITCH_MODE: mode_q <= cfg_data_i[0];
          CFG_LAMBDA_GAIN: lambda_q <= 64'(cfg_data_i);
          CFG_ALPHA_GAIN:  alpha_q <= 64'(cfg_data_i);
          CFG_SMOOTH:      width_q <= 64'(cfg_data_i);
          CFG_STEP_TIME:   dt_q <= 64'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_derivative(sample_i));
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result beat: derivative %0d error %0d",
                                       derivative_i, tracking_error_i);
        end else begin
          want = expected_results.pop_front();
          if (want.derivative !== derivative_i || want.tracking_error !== tracking_error_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch at result %0d: derivative exp %0d got %0d, error exp %0d got %0d",
                       results_o, want.derivative, derivative_i, want.tracking_error,
                       tracking_error_i);
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ sim/super_twisting_differentiator_tb.sv @@
// Stimulus, handshake pacing and verdict for the super-twisting differentiator.
`timescale 1ns / 1ps
module super_twisting_differentiator_tb;
  import stdiff_pkg::*;

  localparam int RUN_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(int'(CFG_STEP_TIME) + 1);
  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [DATA_W-1:0] sample_i, derivative_o, tracking_error_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0] cfg_data_i;

  int errors, pending, results, cycles, samples_sent, cfg_writes;
  int burst_left;

  super_twisting_differentiator uut (.*);

  stdiff_derivative_checker u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_i,
    .out_valid_i(out_valid_o), .out_stall_i, .derivative_i(derivative_o),
    .tracking_error_i(tracking_error_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("super_twisting_differentiator_tb: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure: runs of free flow, solid stall, coin-flip and periodic stall.
  always @(negedge clk_i) begin
    int stall_mode, stall_run;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(3, 60);
      end
      stall_run--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'b1;
        2: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= (stall_run % 4) == 0;
      endcase
    end
  end

  // Drive one sample beat; hold it until taken, then keep valid up within a burst or drop
  // it for a random gap.
  task automatic send_sample(logic [DATA_W-1:0] s);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 25)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, then hold off the sender until every result has drained and the block has
  // gone quiet.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = $urandom_range(1, 12);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Pick a gain: an extreme, its default, or anything.
  function automatic logic [DATA_W-1:0] pick_gain(logic [DATA_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return dflt;
      3: return DATA_W'($urandom_range(0, 1 << 20));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] track;
    logic signed [DATA_W-1:0] slope;
    in_valid_i = 1'b0;
    sample_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SWITCH_MODE;
    cfg_data_i = '0;
    out_stall_i = 1'b0;
    burst_left = 1;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings: zero error, full-scale swings both ways, small steps.
    send_sample('0);
    send_sample('0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(DATA_W'(1));
    send_sample('1);
    send_sample(DATA_W'(32'h0001_0000));
    drain_results();

    // Directed, sigmoid switching with zero width, then the default width.
    write_register(CFG_SWITCH_MODE, DATA_W'(1));
    write_register(CFG_SMOOTH, '0);
    send_sample(DATA_W'(32'h0003_0000));
    send_sample(S_MIN);
    send_sample(S_MAX);
    drain_results();
    write_register(CFG_SMOOTH, SMOOTH_RST);
    send_sample(DATA_W'(32'h0002_8000));
    send_sample('0);
    send_sample(S_MIN);
    drain_results();

    // Directed, every gain at its top value; drive the state into saturation.
    write_register(CFG_SWITCH_MODE, '0);
    write_register(CFG_LAMBDA_GAIN, '1);
    write_register(CFG_ALPHA_GAIN, '1);
    write_register(CFG_SMOOTH, '1);
    write_register(CFG_STEP_TIME, '1);
    write_register(CFG_FIRST_UNUSED, '1);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(S_MIN);
    drain_results();

    // Random phases: fresh settings each time, mostly a smooth trajectory with noise.
    for (int phase = 0; phase < 7; phase++) begin
      write_register(CFG_SWITCH_MODE, DATA_W'($urandom_range(0, 1)) | ($urandom & ~32'h1));
      write_register(CFG_LAMBDA_GAIN, pick_gain(LAMBDA_RST));
      write_register(CFG_ALPHA_GAIN, pick_gain(ALPHA_RST));
      write_register(CFG_SMOOTH, pick_gain(SMOOTH_RST));
      write_register(CFG_STEP_TIME, pick_gain(STEP_RST));
      write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
                     $urandom);
      track = $urandom;
      track = track >>> $urandom_range(0, 16);
      slope = $signed(32'($urandom)) >>> $urandom_range(12, 28);
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0: send_sample($urandom);
          1: send_sample(($urandom_range(0, 1) != 0) ? S_MAX : S_MIN);
          2: send_sample(DATA_W'($urandom_range(0, 3)) - DATA_W'(2));
          default: begin
            track = track + slope + ($signed(32'($urandom)) >>> 22);
            if ($urandom_range(0, 15) == 0)
              slope = $signed(32'($urandom)) >>> $urandom_range(12, 28);
            send_sample(track);
          end
        endcase
      end
      drain_results();
    end

    $display("sent %0d samples over 11 register settings (%0d writes), %0d results checked",
             samples_sent, cfg_writes, results);
    $display("covered sign and sigmoid switching, zero and full-scale gains, saturation");
    if (errors == 0) begin
      $display("super_twisting_differentiator_tb: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("super_twisting_differentiator_tb: done, errors");
    end
    $finish;
  end

endmodule
